[hdl/abm_pkg.sv]
// Shared types and constants for the approximate bitap matcher.
`default_nettype none
package abm_pkg;

  // Default sizing
  localparam int PATTERN_LEN_DEF = 64;
  localparam int MAX_ERRORS_DEF  = 4;

  // Field widths
  localparam int OP_W     = 2;
  localparam int SYM_W    = 8;
  localparam int POS_W    = 6;
  localparam int PLEN_W   = 7;
  localparam int ELIM_W   = 3;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // Item opcodes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_TEXT    = 2'd2
  } op_e;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = 1'b1;

  // Control broadcast to every cell
  typedef struct packed {
    logic             step;
    logic             restart;
    logic             load;
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] position;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[hdl/abm_cell.sv]
// One pattern position: its character and its bit of every error level.
`default_nettype none
module abm_cell
  import abm_pkg::*;
#(
  parameter int LEVELS = MAX_ERRORS_DEF + 1,
  parameter int LEN_W  = 7,
  parameter int LIM_W  = 3,
  parameter int IDX    = 0
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire cell_ctrl_t   ctrl_i,
  input  wire [LEN_W-1:0]   used_len_i,
  input  wire [LIM_W-1:0]   lim_i,
  input  wire [LEVELS-1:0]  prev_old_i,  // old level bits of position IDX-1
  input  wire [LEVELS-1:0]  prev_new_i,  // new level bits of position IDX-1
  output logic [LEVELS-1:0] lvl_old_o,
  output logic [LEVELS-1:0] lvl_new_o,
  output logic              hit_o
);

  localparam bit Addressable = IDX < (2 ** POS_W);

  logic [SYM_W-1:0]  char_q;
  logic [LEVELS-1:0] lvl_q, lvl_d, lvl_new, lvl_init;
  logic              in_use, is_last, mask_bit, wr_en;

  assign in_use  = LEN_W'(IDX) < used_len_i;
  assign is_last = used_len_i == LEN_W'(IDX + 1);
  assign wr_en   = Addressable && ctrl_i.load &&
                   (ctrl_i.position == POS_W'(IDX % (2 ** POS_W)));

  // mask bit is 0 where this pattern character equals the text byte
  assign mask_bit = ~(in_use && (char_q == ctrl_i.symbol));

  always_comb begin
    for (int r = 0; r < LEVELS; r++) begin
      lvl_init[r] = IDX >= r;
    end
    lvl_new[0] = prev_old_i[0] | mask_bit;
    for (int r = 1; r < LEVELS; r++) begin
      lvl_new[r] = (prev_old_i[r] | mask_bit) & prev_old_i[r-1] & lvl_q[r-1] &
                   prev_new_i[r-1];
    end
  end

  always_comb begin
    lvl_d = lvl_q;
    if (ctrl_i.restart) begin
      lvl_d = lvl_init;
    end else if (ctrl_i.step) begin
      lvl_d = lvl_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= lvl_init;
    end else begin
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      char_q <= ctrl_i.symbol;
    end
  end

  generate
    if (LEVELS == 1) begin : g_one
      assign hit_o = is_last & ~lvl_new[0];
    end else begin : g_sel
      assign hit_o = is_last & ~lvl_new[lim_i];
    end
  endgenerate

  assign lvl_old_o = lvl_q;
  assign lvl_new_o = lvl_new;

endmodule
`default_nettype wire

[hdl/approximate_bitap_matcher_unit.sv]
// Approximate bitap matcher: a row of per-position cells with a registered result.
//
//  channel   | dir | handshake             | word contents (low bit up)
//  ----------+-----+-----------------------+-----------------------------------------
//  s_axis    | in  | tvalid/tready         | opcode[1:0] symbol[9:2] position[15:10]
//  m_axis    | out | tvalid/tready         | match_found[0], zeros [7:1]
//  cfg       | in  | cfg_we_i, no wait     | idx 0 pattern_length, idx 1 error_limit
//
// One word per cycle unless stalled; each accepted word gives one result next cycle.
// The critical path is the ripple of new level bits from a cell to its neighbor,
// MAX_ERRORS+1 deep, then the OR over all cell hit taps into the result register.
// Reset is asynchronous; it sets levels to their start values and empties the
// output register. Pattern characters are not reset.
// A waiting result blocks input only while m_axis_tready is low; when it drains,
// a new word is taken in the same cycle.
`default_nettype none
module approximate_bitap_matcher_unit
  import abm_pkg::*;
#(
  parameter int PATTERN_LEN = PATTERN_LEN_DEF,
  parameter int MAX_ERRORS  = MAX_ERRORS_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire [IN_DATA_W-1:0]  s_axis_tdata,   // opcode, symbol, position
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // match_found, zero pad
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_W-1:0]      cfg_wdata_i
);

  localparam int Levels = MAX_ERRORS + 1;
  localparam int LenW   = $clog2(PATTERN_LEN + 1);
  localparam int LimW   = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int CmpW   = (LenW > PLEN_W) ? LenW : PLEN_W;

  // input word unpack
  logic [OP_W-1:0]  in_op;
  logic [SYM_W-1:0] in_sym;
  logic [POS_W-1:0] in_pos;
  assign in_op  = s_axis_tdata[OP_W-1:0];
  assign in_sym = s_axis_tdata[OP_W+SYM_W-1:OP_W];
  assign in_pos = s_axis_tdata[OP_W+SYM_W+POS_W-1:OP_W+SYM_W];

  // configuration, held already saturated
  logic [LenW-1:0] used_len_q, used_len_d;
  logic [LimW-1:0] lim_q, lim_d;
  logic [CmpW-1:0] plen_ext;
  logic [3:0]      elim_ext;

  assign plen_ext = CmpW'(cfg_wdata_i[PLEN_W-1:0]);
  assign elim_ext = {1'b0, cfg_wdata_i[ELIM_W-1:0]};

  always_comb begin
    used_len_d = used_len_q;
    lim_d      = lim_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PATTERN_LENGTH: begin
          if (plen_ext == '0) begin
            used_len_d = LenW'(1);
          end else if (plen_ext > CmpW'(PATTERN_LEN)) begin
            used_len_d = LenW'(PATTERN_LEN);
          end else begin
            used_len_d = LenW'(plen_ext);
          end
        end
        REG_ERROR_LIMIT: begin
          if (elim_ext > 4'(MAX_ERRORS)) begin
            lim_d = LimW'(MAX_ERRORS);
          end else begin
            lim_d = LimW'(elim_ext);
          end
        end
        default: begin
          used_len_d = used_len_q;
        end
      endcase
    end
  end

  // handshake: one result register, input flows when it is free or draining
  logic in_acc;
  logic out_valid_q, out_valid_d;
  logic out_match_q, out_match_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  cell_ctrl_t ctrl;
  always_comb begin
    ctrl.step     = in_acc && (in_op == OP_TEXT);
    ctrl.restart  = in_acc && (in_op == OP_RESTART);
    ctrl.load     = in_acc && (in_op == OP_LOAD);
    ctrl.symbol   = in_sym;
    ctrl.position = in_pos;
  end

  // cell row; position 0 sees zeros shifted in
  logic [Levels-1:0]      old_bits [PATTERN_LEN];
  logic [Levels-1:0]      new_bits [PATTERN_LEN];
  logic [PATTERN_LEN-1:0] hits;

  generate
    for (genvar i = 0; i < PATTERN_LEN; i++) begin : g_cell
      logic [Levels-1:0] p_old, p_new;
      if (i == 0) begin : g_head
        assign p_old = '0;
        assign p_new = '0;
      end else begin : g_link
        assign p_old = old_bits[i-1];
        assign p_new = new_bits[i-1];
      end
      abm_cell #(
        .LEVELS (Levels),
        .LEN_W  (LenW),
        .LIM_W  (LimW),
        .IDX    (i)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .used_len_i (used_len_q),
        .lim_i      (lim_q),
        .prev_old_i (p_old),
        .prev_new_i (p_new),
        .lvl_old_o  (old_bits[i]),
        .lvl_new_o  (new_bits[i]),
        .hit_o      (hits[i])
      );
    end
  endgenerate

  always_comb begin
    out_valid_d = out_valid_q;
    out_match_d = out_match_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
      out_match_d = (in_op == OP_TEXT) && (|hits);
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_len_q  <= LenW'(1);
      lim_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      used_len_q  <= used_len_d;
      lim_q       <= lim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_match_q <= out_match_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - 1)'(0), out_match_q};

endmodule
`default_nettype wire

[hdl/abm_checker.sv]
// Port-level checks for the approximate bitap matcher, bound to the top level.
`default_nettype none
module abm_checker
  import abm_pkg::*;
(
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  s_axis_tvalid,
  input wire                  s_axis_tready,
  input wire [IN_DATA_W-1:0]  s_axis_tdata,
  input wire                  m_axis_tvalid,
  input wire                  m_axis_tready,
  input wire [OUT_DATA_W-1:0] m_axis_tdata,
  input wire                  cfg_we_i,
  input wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input wire [CFG_W-1:0]      cfg_wdata_i
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // result word holds while stalled
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed while stalled");

  // every accepted word yields a result in the next cycle
  a_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // only text words can report a match
  a_non_text_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tdata[OP_W-1:0] != OP_TEXT) |=> m_axis_tdata[0] == 1'b0)
    else $error("match reported for a non-text word");

  // an empty output register never blocks input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind approximate_bitap_matcher_unit abm_checker u_abm_checker (.*);
`default_nettype wire

[dv/approximate_bitap_matcher_unit_checker.sv]
// Checker for the approximate bitap matcher: watches the streams, predicts match flags, compares.
module approximate_bitap_matcher_unit_checker
  import abm_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_ready_i,
  input  wire [IN_DATA_W-1:0]  in_data_i,   // opcode, symbol, position
  input  wire                  out_valid_i,
  input  wire                  out_ready_i,
  input  wire [OUT_DATA_W-1:0] out_data_i,  // match_found, zero pad
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_W-1:0]      cfg_wdata_i,
  output int                   err_cnt_o,
  output int                   pending_o,
  output int                   result_cnt_o,
  output int                   match_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LEVELS = MAX_ERRORS_DEF + 1;
  localparam int NUM_POS    = PATTERN_LEN_DEF;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [SYM_W-1:0] symbol;
    logic [OP_W-1:0]  opcode;
  } in_word_t;

  logic [SYM_W-1:0]   pat_chars [NUM_POS];
  logic [NUM_POS-1:0] lvl [NUM_LEVELS];
  logic [PLEN_W-1:0]  plen;
  logic [ELIM_W-1:0]  elim;
  logic               match_due_q [$];

  function automatic void restart_levels();
    for (int r = 0; r < NUM_LEVELS; r++) lvl[r] = {NUM_POS{1'b1}} << r;
  endfunction

  // One shift-or step over all levels; returns the match flag at the active limit.
  function automatic logic advance_levels(input logic [SYM_W-1:0] c);
    logic [NUM_POS-1:0] cmask;
    logic [NUM_POS-1:0] below_old;
    logic [NUM_POS-1:0] keep;
    int m;
    int lim;
    m   = (plen == 0) ? 1 : (plen > NUM_POS) ? NUM_POS : int'(plen);
    lim = (elim > MAX_ERRORS_DEF) ? MAX_ERRORS_DEF : int'(elim);
    cmask = '1;
    for (int i = 0; i < m; i++) if (pat_chars[i] == c) cmask[i] = 1'b0;
    below_old = lvl[0];
    lvl[0] = (lvl[0] << 1) | cmask;
    for (int r = 1; r < NUM_LEVELS; r++) begin
      keep = lvl[r];
      lvl[r] = ((lvl[r] << 1) | cmask) & (below_old << 1) & below_old & (lvl[r-1] << 1);
      below_old = keep;
    end
    return !lvl[lim][m-1];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    in_word_t w;
    logic     want;
    if (!rst_ni) begin
      plen = 1;
      elim = 0;
      restart_levels();
      match_due_q.delete();
      err_cnt_o    = 0;
      pending_o    = 0;
      result_cnt_o = 0;
      match_cnt_o  = 0;
    end else begin
      // results first: a word accepted now answers in the next cycle at the earliest
      if (out_valid_i && out_ready_i) begin
        result_cnt_o++;
        if (out_data_i[0] === 1'b1) match_cnt_o++;
        if (match_due_q.size() == 0) begin
          if (err_cnt_o < 10) $display("%0t: result word %0h with nothing pending",
                                       $realtime, out_data_i);
          err_cnt_o++;
        end else begin
          want = match_due_q.pop_front();
          if (out_data_i[0] !== want) begin
            if (err_cnt_o < 10) $display("%0t: match_found expected %0b, got %0b",
                                         $realtime, want, out_data_i[0]);
            err_cnt_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        w = in_data_i;
        want = 1'b0;
        case (w.opcode)
          OP_LOAD:    pat_chars[w.position] = w.symbol;
          OP_RESTART: restart_levels();
          OP_TEXT:    want = advance_levels(w.symbol);
          default: ;
        endcase
        match_due_q.push_back(want);
      end
      // a register write counts from the next word on
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PATTERN_LENGTH: plen = cfg_wdata_i[PLEN_W-1:0];
          REG_ERROR_LIMIT:    elim = cfg_wdata_i[ELIM_W-1:0];
          default: ;
        endcase
      end
      pending_o = match_due_q.size();
    end
  end

endmodule

[dv/approximate_bitap_matcher_unit_tb.sv]
// Testbench top for the approximate bitap matcher: clock, reset, stimulus and verdict.
module approximate_bitap_matcher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import abm_pkg::*;

  // opcode value the block must ignore; the package names only the live ones
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 80;     // long receiver hold-off
  localparam int WORD_TARGET  = 430;    // directed part and random phases, at least this many in all
  localparam int WATCHDOG_NS  = 5_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // opcode[1:0], symbol[9:2], position[15:10]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // match_found[0], zero pad [7:1]
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_W-1:0]      cfg_wdata;

  int err_cnt, pending, result_cnt, match_cnt;

  // stimulus bookkeeping
  int src_idle_pct;
  int sink_stall_pct;
  int words_sent;
  int reg_writes;
  int phases;
  int cur_len;                               // pattern length the block really uses
  bit hold_on;
  event hold_ev;
  logic [SYM_W-1:0] pat_img [PATTERN_LEN_DEF];
  bit               loaded  [PATTERN_LEN_DEF]; // never text-step over an unloaded position
  logic [SYM_W-1:0] alphabet [4];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  approximate_bitap_matcher_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  approximate_bitap_matcher_unit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .err_cnt_o    (err_cnt),
    .pending_o    (pending),
    .result_cnt_o (result_cnt),
    .match_cnt_o  (match_cnt)
  );

  // Receiver: random stalls at the falling edge, forced low while a hold-off runs.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_on) m_axis_tready <= 1'b0;
      else         m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Hold-off counter, kept apart from the sender so the sender keeps pushing words.
  initial begin
    hold_on = 1'b0;
    forever begin
      @(hold_ev);
      @(posedge clk_i);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on = 1'b0;
    end
  end

  // Offer one word, with random idle cycles ahead of it; returns at the falling
  // edge after acceptance with valid still high, so back-to-back words need no
  // second assignment in the same step.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                           input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, sym, op};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic load_char(input int pos, input logic [SYM_W-1:0] sym);
    pat_img[pos] = sym;
    loaded[pos]  = 1'b1;
    send_word(OP_LOAD, sym, POS_W'(pos));
  endtask

  // Stop offering and let every pending result come back.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Only called while the block is idle; both registers every time.
  task automatic set_regs(input int pl, input int el);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_PATTERN_LENGTH;
    cfg_wdata <= CFG_W'(pl);
    @(negedge clk_i);
    cfg_idx   <= REG_ERROR_LIMIT;
    cfg_wdata <= CFG_W'(el);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
    reg_writes += 2;
    cur_len = (pl == 0) ? 1 : (pl > PATTERN_LEN_DEF) ? PATTERN_LEN_DEF : pl;
  endtask

  // Mostly symbols from a small per-phase alphabet so that hits are frequent.
  function automatic logic [SYM_W-1:0] pick_sym();
    return ($urandom_range(99) < 85) ? alphabet[$urandom_range(3)] : SYM_W'($urandom_range(255));
  endfunction

  // Text run: a copy of the pattern with a few substitutions, insertions and
  // deletions, some leading noise, and the odd restart, unused opcode or reload.
  task automatic send_near_copy(input int max_edits);
    logic [SYM_W-1:0] seq [$];
    int at;
    repeat ($urandom_range(2)) seq.push_back(pick_sym());
    for (int j = 0; j < cur_len; j++) seq.push_back(pat_img[j]);
    repeat ($urandom_range(max_edits)) begin
      at = $urandom_range(seq.size() - 1);
      case ($urandom_range(2))
        0:       seq[at] = pick_sym();
        1:       seq.insert(at, pick_sym());
        default: if (seq.size() > 1) seq.delete(at);
      endcase
    end
    foreach (seq[j]) begin
      case ($urandom_range(49))
        0: send_word(OP_RESTART, SYM_W'($urandom_range(255)), POS_W'($urandom_range(63)));
        1: send_word(OP_UNUSED, SYM_W'($urandom_range(255)), POS_W'($urandom_range(63)));
        2: load_char($urandom_range(63), pick_sym());
        default: ;
      endcase
      send_word(OP_TEXT, seq[j], POS_W'($urandom_range(63)));
    end
  endtask

  initial begin : stim
    int pl;
    int el;
    int phase_start;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    words_sent     = 0;
    reg_writes     = 0;
    phases         = 0;
    cur_len        = 1;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed part, no idling ----
    set_regs(4, 1);
    load_char(0, 8'hFF);
    load_char(1, 8'h00);
    load_char(2, 8'h5A);
    load_char(3, 8'hA5);
    load_char(63, 8'h3C);                          // top position, outside the pattern
    send_word(OP_RESTART, 8'h00, 6'd0);
    // exact occurrence, then one substitution, then one deletion
    foreach (pat_img[j]) if (j < 4) send_word(OP_TEXT, pat_img[j], 6'd63);
    send_word(OP_TEXT, 8'hFF, 6'd0);
    send_word(OP_TEXT, 8'h00, 6'd0);
    send_word(OP_TEXT, 8'h33, 6'd0);
    send_word(OP_TEXT, 8'hA5, 6'd0);
    send_word(OP_TEXT, 8'hFF, 6'd0);
    send_word(OP_TEXT, 8'h5A, 6'd0);
    send_word(OP_TEXT, 8'hA5, 6'd0);
    send_word(OP_UNUSED, 8'hFF, 6'd63);            // must change nothing
    // length zero acts as one, limit seven saturates; levels carry over, no restart
    wait_drain();
    set_regs(0, 7);
    send_word(OP_TEXT, 8'h00, 6'd0);
    send_word(OP_TEXT, 8'hFF, 6'd0);
    wait_drain();
    set_regs(4, 0);
    send_word(OP_TEXT, 8'h00, 6'd0);
    send_word(OP_TEXT, 8'h5A, 6'd0);
    send_word(OP_TEXT, 8'hA5, 6'd0);

    // ---- random phases: idle mode rotates, pattern and limits change each phase ----
    for (int p = 0; words_sent < WORD_TARGET; p++) begin
      phases++;
      wait_drain();                                // sender waits for every result here
      case (p % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 52; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 52; end
        default: begin src_idle_pct = 28; sink_stall_pct = 28; end
      endcase
      foreach (alphabet[k]) alphabet[k] = SYM_W'($urandom_range(255));
      // mostly short patterns; full length and the saturating range only a few times
      case (p)
        2:       pl = PATTERN_LEN_DEF;
        5:       pl = 127;
        8:       pl = $urandom_range(PATTERN_LEN_DEF + 1, 126);
        default: pl = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
      endcase
      el = ($urandom_range(3) == 0) ? $urandom_range(MAX_ERRORS_DEF + 1, 7)
                                    : $urandom_range(0, MAX_ERRORS_DEF);
      set_regs(pl, el);
      for (int i = 0; i < cur_len; i++)
        if (!loaded[i] || $urandom_range(99) < (cur_len > 16 ? 5 : 60)) load_char(i, pick_sym());
      send_word(OP_RESTART, SYM_W'($urandom_range(255)), POS_W'($urandom_range(63)));
      if (p == 0) -> hold_ev;                      // receiver blocks, input backs up
      phase_start = words_sent;
      do send_near_copy(2); while (words_sent - phase_start < 30);
    end

    wait_drain();
    repeat (8) @(negedge clk_i);
    $display("Sent %0d words (loads, restarts, text, unused opcode), checked %0d results, %0d hits.",
             words_sent, result_cnt, match_cnt);
    $display("%0d register writes over %0d random phases, lengths 0..127, limits 0..7.",
             reg_writes, phases);
    if (err_cnt == 0) begin
      $display("[approximate_bitap_matcher_unit] OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("[approximate_bitap_matcher_unit] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #WATCHDOG_NS;
    $display("watchdog expired, %0d results outstanding", pending);
    $display("[approximate_bitap_matcher_unit] ERROR");
    $finish;
  end

endmodule
